[sv/max_square_window_sum_core_macros.svh]
// Assertion macros for the max square window sum core.
`ifndef MAX_SQUARE_WINDOW_SUM_CORE_MACROS_SVH
`define MAX_SQUARE_WINDOW_SUM_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MSSW_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MSSW_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSSW_CHK(lbl, ante, cons, msg)
`define MSSW_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/mssw_pkg.sv]
// Shared types and constants for the max square window sum core.
`timescale 1ns / 1ps
package mssw_pkg;

  localparam int CELL_W     = 16;
  localparam int COLSUM_W   = 24;
  localparam int DIFF_W     = 25;
  localparam int SUM_W      = 32;
  localparam int POS_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int SIDE_CFG_W = 7;

  localparam int GRID_RST = 1024;
  localparam int SIDE_RST = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIDE = 2'd2;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  typedef logic signed [CELL_W-1:0]   cell_t;
  typedef logic signed [COLSUM_W-1:0] colsum_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [POS_W-1:0]           pos_t;

  typedef struct packed {
    pos_t best_row;
    pos_t best_col;
    sum_t best_sum;
    logic window_found;
  } res_t;

endpackage

[sv/mssw_in_if.sv]
// Input cell channel: valid/ready plus one cell value per beat.
`timescale 1ns / 1ps
interface mssw_in_if;
  logic            valid;
  logic            ready;
  mssw_pkg::cell_t cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

[sv/mssw_out_if.sv]
// Result channel: valid/ready plus best window corner, sum and found flag.
`timescale 1ns / 1ps
interface mssw_out_if;
  logic           valid;
  logic           ready;
  mssw_pkg::pos_t best_row;
  mssw_pkg::pos_t best_col;
  mssw_pkg::sum_t best_sum;
  logic           window_found;

  modport source (output valid, output best_row, output best_col, output best_sum,
                  output window_found, input ready);
  modport sink (input valid, input best_row, input best_col, input best_sum,
                input window_found, output ready);
endinterface

[sv/max_square_window_sum_core.sv]
// Max square window sum core: line buffer, column sum memory, strip sum and best tracker.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------
//  in_ch   | in  | cell_value, one grid cell, row-major
//  out_ch  | out | best_row, best_col, best_sum, window_found
//  cfg_*   | in  | cfg_we, cfg_idx, cfg_wdata (write only)
//
//  One cell per cycle while in_ch.ready is high; a cell passes the s1, s2 and s3 registers
//  before the best tracker, and a grid's result beat is offered from the result FIFO.
//  The column sum memory is read at accept and written in the cycle after, from stage 1; same-entry
//  overlap is covered by a one-deep forward. Results queue in an 8-entry FIFO;
//  in_ch.ready drops only in reset or when queued plus in-flight results would fill it.
//  Synchronous reset; no clearing pass, every memory read is preceded by a write.
`timescale 1ns / 1ps
`include "max_square_window_sum_core_macros.svh"
module max_square_window_sum_core #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  parameter int MAX_SIDE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  mssw_in_if.sink                            in_ch,
  mssw_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [mssw_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [mssw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PH_W     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int RS_DEPTH = 2 ** (PH_W + COL_W);
  localparam int ROWS_RST = (MAX_ROWS < mssw_pkg::GRID_RST) ? MAX_ROWS : mssw_pkg::GRID_RST;
  localparam int COLS_RST = (MAX_COLS < mssw_pkg::GRID_RST) ? MAX_COLS : mssw_pkg::GRID_RST;
  localparam int SIDE_RV  = (MAX_SIDE < mssw_pkg::SIDE_RST) ? MAX_SIDE : mssw_pkg::SIDE_RST;

  typedef struct packed {
    mssw_pkg::cell_t v;
    logic [COL_W-1:0] c;
    logic r_zero;
    logic old_ok;
    logic sub_ok;
    logic c0;
    logic win;
    logic [ROW_W-1:0] tr;
    logic [COL_W-1:0] tc;
    logic ge;
  } s1_t;

  typedef struct packed {
    mssw_pkg::diff_t diff;
    logic c0;
    logic win;
    logic [ROW_W-1:0] tr;
    logic [COL_W-1:0] tc;
    logic ge;
  } s2_t;

  typedef struct packed {
    logic win;
    logic [ROW_W-1:0] tr;
    logic [COL_W-1:0] tc;
    logic ge;
  } s3_t;

  // configuration, stored as clamped value minus one
  logic [ROW_W-1:0] rows_m1_r, rows_m1_nxt;
  logic [COL_W-1:0] cols_m1_r, cols_m1_nxt;
  logic [PH_W-1:0]  side_m1_r, side_m1_nxt;

  // position of the next cell
  logic [ROW_W-1:0] r_r, r_nxt;
  logic [COL_W-1:0] c_r, c_nxt;
  logic [PH_W-1:0]  ph_r, ph_nxt;

  logic s1_v_r, s2_v_r, s3_v_r;
  s1_t  s1_r;
  s2_t  s2_r;
  s3_t  s3_r;

  mssw_pkg::cell_t   row_store [RS_DEPTH];
  mssw_pkg::colsum_t col_mem [MAX_COLS];
  mssw_pkg::cell_t   rs_q_r;
  mssw_pkg::colsum_t csa_q_r, csb_q_r, colfwd_r;
  logic              fwda_r, fwdb_r;

  mssw_pkg::sum_t    strip_r;
  mssw_pkg::sum_t    top_sum_r, top_sum_nxt;
  logic [ROW_W-1:0]  top_row_r, top_row_nxt;
  logic [COL_W-1:0]  top_col_r, top_col_nxt;
  logic              have_top_r, have_top_nxt;

  mssw_pkg::res_t                  res_mem [mssw_pkg::FIFO_DEPTH];
  mssw_pkg::res_t                  res_new;
  logic [mssw_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [mssw_pkg::FIFO_CNT_W-1:0] fifo_cnt_r, pend;

  logic acc, push, pop, row_end, grid_end, better;
  logic [PH_W+COL_W-1:0] rs_addr;
  logic [COL_W-1:0]      csb_addr;
  mssw_pkg::colsum_t     cs_prev, old_ext, sub, col_now;
  s1_t                   s1_new;

  assign acc  = in_ch.valid && in_ch.ready;
  assign push = s3_v_r && s3_r.ge;
  assign pop  = out_ch.valid && out_ch.ready;
  assign pend = fifo_cnt_r + mssw_pkg::FIFO_CNT_W'(s1_v_r && s1_r.ge)
              + mssw_pkg::FIFO_CNT_W'(s2_v_r && s2_r.ge)
              + mssw_pkg::FIFO_CNT_W'(s3_v_r && s3_r.ge);
  assign in_ch.ready = rst_n && (pend < mssw_pkg::FIFO_CNT_W'(mssw_pkg::FIFO_DEPTH));

  // configuration writes, clamped on the way in
  always_comb begin
    int wv;
    int ws;
    wv = int'(cfg_wdata);
    ws = int'(cfg_wdata[mssw_pkg::SIDE_CFG_W-1:0]);
    rows_m1_nxt = rows_m1_r;
    cols_m1_nxt = cols_m1_r;
    side_m1_nxt = side_m1_r;
    if (cfg_we) begin
      case (cfg_idx)
        mssw_pkg::REG_GRID_ROWS: begin
          rows_m1_nxt = (wv == 0) ? '0 : ROW_W'(((wv > MAX_ROWS) ? MAX_ROWS : wv) - 1);
        end
        mssw_pkg::REG_GRID_COLS: begin
          cols_m1_nxt = (wv == 0) ? '0 : COL_W'(((wv > MAX_COLS) ? MAX_COLS : wv) - 1);
        end
        mssw_pkg::REG_WINDOW_SIDE: begin
          side_m1_nxt = (ws == 0) ? '0 : PH_W'(((ws > MAX_SIDE) ? MAX_SIDE : ws) - 1);
        end
        default: begin
        end
      endcase
    end
  end

  // position tracking and stage 0 decode
  always_comb begin
    row_end  = (c_r == cols_m1_r);
    grid_end = row_end && (r_r == rows_m1_r);
    r_nxt  = r_r;
    c_nxt  = c_r;
    ph_nxt = ph_r;
    if (cfg_we) begin
      r_nxt  = '0;
      c_nxt  = '0;
      ph_nxt = '0;
    end else if (acc) begin
      if (row_end) begin
        c_nxt  = '0;
        r_nxt  = grid_end ? '0 : r_r + 1'b1;
        ph_nxt = (grid_end || ph_r == side_m1_r) ? '0 : ph_r + 1'b1;
      end else begin
        c_nxt = c_r + 1'b1;
      end
    end
    rs_addr  = {ph_r, c_r};
    csb_addr = COL_W'(int'(c_r) - int'(side_m1_r) - 1);
    s1_new.v      = in_ch.cell_value;
    s1_new.c      = c_r;
    s1_new.r_zero = (r_r == '0);
    s1_new.old_ok = int'(r_r) > int'(side_m1_r);
    s1_new.sub_ok = int'(c_r) > int'(side_m1_r);
    s1_new.c0     = (c_r == '0);
    s1_new.win    = (int'(r_r) >= int'(side_m1_r)) && (int'(c_r) >= int'(side_m1_r));
    s1_new.tr     = ROW_W'(int'(r_r) - int'(side_m1_r));
    s1_new.tc     = COL_W'(int'(c_r) - int'(side_m1_r));
    s1_new.ge     = grid_end;
  end

  // stage 1: column sum update
  always_comb begin
    cs_prev = s1_r.r_zero ? '0 : (fwda_r ? colfwd_r : csa_q_r);
    old_ext = s1_r.old_ok ? mssw_pkg::COLSUM_W'(rs_q_r) : '0;
    col_now = cs_prev + mssw_pkg::COLSUM_W'(s1_r.v) - old_ext;
    sub     = s1_r.sub_ok ? (fwdb_r ? colfwd_r : csb_q_r) : '0;
  end

  // stage 3: best window and result
  always_comb begin
    better = s3_v_r && s3_r.win && (!have_top_r || (strip_r > top_sum_r));
    top_sum_nxt  = better ? strip_r : top_sum_r;
    top_row_nxt  = better ? s3_r.tr : top_row_r;
    top_col_nxt  = better ? s3_r.tc : top_col_r;
    have_top_nxt = have_top_r || better;
    res_new.window_found = have_top_nxt;
    res_new.best_row     = have_top_nxt ? mssw_pkg::POS_W'(top_row_nxt) + 1'b1 : '0;
    res_new.best_col     = have_top_nxt ? mssw_pkg::POS_W'(top_col_nxt) + 1'b1 : '0;
    res_new.best_sum     = have_top_nxt ? top_sum_nxt : '0;
    if (push || cfg_we) begin
      have_top_nxt = 1'b0;
    end
  end

  // line buffer: read the leaving cell and store the new one in the same beat
  always_ff @(posedge clk) begin
    if (acc) begin
      rs_q_r             <= row_store[rs_addr];
      row_store[rs_addr] <= in_ch.cell_value;
    end
  end

  // column sum memory, two reads at accept, one write from stage 1
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      col_mem[s1_r.c] <= col_now;
    end
    if (acc) begin
      csa_q_r  <= col_mem[c_r];
      csb_q_r  <= col_mem[csb_addr];
      fwda_r   <= s1_v_r && (s1_r.c == c_r);
      fwdb_r   <= s1_v_r && (s1_r.c == csb_addr);
      colfwd_r <= col_now;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_new;
    end
    if (s1_v_r) begin
      s2_r.diff <= mssw_pkg::DIFF_W'(col_now) - mssw_pkg::DIFF_W'(sub);
      s2_r.c0   <= s1_r.c0;
      s2_r.win  <= s1_r.win;
      s2_r.tr   <= s1_r.tr;
      s2_r.tc   <= s1_r.tc;
      s2_r.ge   <= s1_r.ge;
    end
    if (s2_v_r) begin
      strip_r   <= (s2_r.c0 ? '0 : strip_r) + mssw_pkg::SUM_W'(s2_r.diff);
      s3_r.win  <= s2_r.win;
      s3_r.tr   <= s2_r.tr;
      s3_r.tc   <= s2_r.tc;
      s3_r.ge   <= s2_r.ge;
    end
    top_sum_r <= top_sum_nxt;
    top_row_r <= top_row_nxt;
    top_col_r <= top_col_nxt;
    if (push) begin
      res_mem[wr_ptr_r] <= res_new;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m1_r  <= ROW_W'(ROWS_RST - 1);
      cols_m1_r  <= COL_W'(COLS_RST - 1);
      side_m1_r  <= PH_W'(SIDE_RV - 1);
      r_r        <= '0;
      c_r        <= '0;
      ph_r       <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      have_top_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      rows_m1_r  <= rows_m1_nxt;
      cols_m1_r  <= cols_m1_nxt;
      side_m1_r  <= side_m1_nxt;
      r_r        <= r_nxt;
      c_r        <= c_nxt;
      ph_r       <= ph_nxt;
      s1_v_r     <= acc;
      s2_v_r     <= s1_v_r;
      s3_v_r     <= s2_v_r;
      have_top_r <= have_top_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + mssw_pkg::FIFO_CNT_W'(push) - mssw_pkg::FIFO_CNT_W'(pop);
    end
  end

  assign out_ch.valid        = (fifo_cnt_r != '0);
  assign out_ch.best_row     = res_mem[rd_ptr_r].best_row;
  assign out_ch.best_col     = res_mem[rd_ptr_r].best_col;
  assign out_ch.best_sum     = res_mem[rd_ptr_r].best_sum;
  assign out_ch.window_found = res_mem[rd_ptr_r].window_found;

  `MSSW_CHK(a_col_in_grid, 1'b1, c_r <= cols_m1_r, "column position past grid width")
  `MSSW_CHK(a_phase_in_side, 1'b1, ph_r <= side_m1_r, "line buffer phase past window side")
  `MSSW_CHK(a_fifo_room, push, (int'(fifo_cnt_r) < mssw_pkg::FIFO_DEPTH) || pop, "FIFO overflow")
  `MSSW_NEXT(a_stage1_follows, acc, s1_v_r, "accepted beat did not reach stage 1")
  `MSSW_NEXT(a_top_cleared, push, !have_top_r, "best window not cleared after grid end")

endmodule

[sim/testbench.sv]
// Testbench for max_square_window_sum_core: random grids checked against a best-window tracker.
`timescale 1ns / 1ps
module testbench;

  localparam int GRID_MAX      = 1024;
  localparam int SIDE_MAX      = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam logic [mssw_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                            clk   = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we;
  logic [mssw_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [mssw_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mssw_in_if  in_ch ();
  mssw_out_if out_ch ();

  max_square_window_sum_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow registers and window tracker state
  logic [mssw_pkg::CFG_DATA_W-1:0] rows_reg;
  logic [mssw_pkg::CFG_DATA_W-1:0] cols_reg;
  logic [mssw_pkg::SIDE_CFG_W-1:0] side_reg;
  logic [mssw_pkg::CELL_W-1:0]     line_buf [SIDE_MAX*GRID_MAX];
  logic [mssw_pkg::COLSUM_W-1:0]   col_acc [GRID_MAX];
  int unsigned                     at_row;
  int unsigned                     at_col;
  int                              strip_acc;
  int                              best_acc;
  int unsigned                     best_r;
  int unsigned                     best_c;
  bit                              have_best;

  mssw_pkg::res_t  expected_windows[$];
  mssw_pkg::cell_t cell_queue[$];
  int    send_idle_pct;
  int    recv_idle_pct;
  int    error_count   = 0;
  int    windows_seen  = 0;
  int    cells_queued  = 0;
  int    quiet_cycles  = 0;
  bit    paused_once   = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void restart_grid();
    at_row    = 0;
    at_col    = 0;
    strip_acc = 0;
    best_acc  = 0;
    best_r    = 0;
    best_c    = 0;
    have_best = 1'b0;
  endfunction

  function automatic void apply_reg(logic [mssw_pkg::CFG_IDX_W-1:0] idx,
                                    logic [mssw_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mssw_pkg::REG_GRID_ROWS:   rows_reg = data;
      mssw_pkg::REG_GRID_COLS:   cols_reg = data;
      mssw_pkg::REG_WINDOW_SIDE: side_reg = data[mssw_pkg::SIDE_CFG_W-1:0];
      default: ;
    endcase
    restart_grid();
  endfunction

  function automatic int sext24(logic [mssw_pkg::COLSUM_W-1:0] x);
    mssw_pkg::colsum_t s;
    s = x;
    return s;
  endfunction

  function automatic void track_best_window(mssw_pkg::cell_t cell_in);
    int unsigned     rows, cols, side, r, c, slot;
    int              v, old, col_now;
    mssw_pkg::cell_t prev;
    mssw_pkg::res_t  win;
    rows = clamp_dim(rows_reg, GRID_MAX);
    cols = clamp_dim(cols_reg, GRID_MAX);
    side = clamp_dim(side_reg, SIDE_MAX);
    r    = at_row;
    c    = at_col;
    if (c >= GRID_MAX) c = GRID_MAX - 1;
    v    = cell_in;
    slot = (r % side) * GRID_MAX + c;
    prev = line_buf[slot];
    old  = (r >= side) ? int'(prev) : 0;
    line_buf[slot] = cell_in;

    col_now    = (r == 0) ? v : sext24(col_acc[c]) + v - old;
    col_acc[c] = col_now[mssw_pkg::COLSUM_W-1:0];
    col_now    = sext24(col_now[mssw_pkg::COLSUM_W-1:0]);

    if (c == 0) strip_acc = col_now;
    else strip_acc = strip_acc + col_now - ((c >= side) ? sext24(col_acc[c - side]) : 0);

    if (r + 1 >= side && c + 1 >= side && (!have_best || strip_acc > best_acc)) begin
      best_acc  = strip_acc;
      best_r    = r + 1 - side;
      best_c    = c + 1 - side;
      have_best = 1'b1;
    end

    if (c + 1 >= cols) begin
      at_col = 0;
      at_row = r + 1;
    end else begin
      at_col = c + 1;
    end

    if (c + 1 >= cols && r + 1 >= rows) begin
      win = '0;
      if (have_best) begin
        win.best_row     = mssw_pkg::pos_t'(best_r + 1);
        win.best_col     = mssw_pkg::pos_t'(best_c + 1);
        win.best_sum     = best_acc;
        win.window_found = 1'b1;
      end
      expected_windows.push_back(win);
      restart_grid();
    end
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  task automatic check_window();
    mssw_pkg::res_t want;
    if (expected_windows.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: row %0d col %0d sum %0d found %0b",
                                out_ch.best_row, out_ch.best_col, out_ch.best_sum,
                                out_ch.window_found));
    end else begin
      want = expected_windows.pop_front();
      if (out_ch.best_row !== want.best_row)
        report_mismatch($sformatf("best_row %0d, want %0d", out_ch.best_row, want.best_row));
      if (out_ch.best_col !== want.best_col)
        report_mismatch($sformatf("best_col %0d, want %0d", out_ch.best_col, want.best_col));
      if (out_ch.best_sum !== want.best_sum)
        report_mismatch($sformatf("best_sum %0d, want %0d", out_ch.best_sum, want.best_sum));
      if (out_ch.window_found !== want.window_found)
        report_mismatch($sformatf("window_found %0b, want %0b", out_ch.window_found,
                                  want.window_found));
    end
  endtask

  // cell driver; the tracker runs on every accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.cell_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) track_best_window(in_ch.cell_value);
      if (!in_ch.valid || in_ch.ready) begin
        if (cell_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid      <= 1'b1;
          in_ch.cell_value <= cell_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        windows_seen++;
        check_window();
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic mssw_pkg::cell_t rand_cell();
    case ($urandom_range(0, 7))
      0: return mssw_pkg::cell_t'(16'h8000);
      1: return mssw_pkg::cell_t'(16'h7fff);
      2: return '0;
      default: return mssw_pkg::cell_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic hold_for_results();
    while (cell_queue.size() != 0 || in_ch.valid) @(negedge clk);
    while (expected_windows.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [mssw_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data[mssw_pkg::CFG_DATA_W-1:0];
    apply_reg(idx, data[mssw_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic set_grid(int unsigned rows_w, int unsigned cols_w, int unsigned side_w);
    settle();
    write_reg(mssw_pkg::REG_GRID_ROWS, rows_w);
    write_reg(mssw_pkg::REG_GRID_COLS, cols_w);
    write_reg(mssw_pkg::REG_WINDOW_SIDE, side_w);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // unused index: no register changes, grid restarts
  task automatic poke_spare();
    settle();
    write_reg(REG_SPARE, $urandom_range(0, 2047));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_grids(int unsigned n_grids, bit pause_mid);
    int unsigned n_cells;
    int unsigned g;
    n_cells = clamp_dim(rows_reg, GRID_MAX) * clamp_dim(cols_reg, GRID_MAX);
    for (g = 0; g < n_grids; g++) begin
      if (pause_mid && g == n_grids / 2 && g != 0) begin
        hold_for_results();
        paused_once = 1'b1;
      end
      repeat (n_cells) cell_queue.push_back(rand_cell());
      cells_queued += n_cells;
    end
  endtask

  initial begin
    int unsigned rows_w, cols_w, side_w, n_cells, part;
    int          mode_cells, mode_windows;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    rows_reg         = mssw_pkg::GRID_RST;
    cols_reg         = mssw_pkg::GRID_RST;
    side_reg         = mssw_pkg::SIDE_RST;
    foreach (line_buf[i]) line_buf[i] = '0;
    foreach (col_acc[i]) col_acc[i] = '0;
    restart_grid();
    send_idle_pct = 30;
    recv_idle_pct = 48;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero rows and zero side clamp to one
    set_grid(0, 3, 0);
    cell_queue.push_back(mssw_pkg::cell_t'(16'h7fff));
    cell_queue.push_back(mssw_pkg::cell_t'(16'h8000));
    cell_queue.push_back('0);
    // window larger than grid
    set_grid(2, 2, 3);
    repeat (4) cell_queue.push_back(mssw_pkg::cell_t'(-1));
    // all windows tie at a negative sum
    set_grid(2, 3, 2);
    repeat (6) cell_queue.push_back(mssw_pkg::cell_t'(-7));
    // partial grid dropped by a write to the unused index
    set_grid(2, 2, 1);
    repeat (3) cell_queue.push_back(rand_cell());
    poke_spare();
    repeat (4) cell_queue.push_back(rand_cell());

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 48;
          set_grid(3, 40, 127);
          push_grids(1, 1'b0);
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 30;
          set_grid(9, 12, 3);
          push_grids(1, 1'b0);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          set_grid(2, 60, 2);
          push_grids(1, 1'b0);
        end
      endcase
      mode_cells   = cells_queued;
      mode_windows = windows_seen;
      while (cells_queued - mode_cells < 250 || windows_seen - mode_windows < 8) begin
        rows_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 8);
        cols_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 10);
        side_w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 5);
        set_grid(rows_w, cols_w, side_w);
        n_cells = clamp_dim(rows_reg, GRID_MAX) * clamp_dim(cols_reg, GRID_MAX);
        if (n_cells > 1 && $urandom_range(0, 5) == 0) begin
          part = $urandom_range(1, n_cells - 1);
          repeat (part) cell_queue.push_back(rand_cell());
          cells_queued += part;
          poke_spare();
        end
        push_grids($urandom_range(1, 3), !paused_once || $urandom_range(0, 7) == 0);
        wait (windows_seen - mode_windows >= 0);
      end
    end

    settle();
    if (error_count == 0 && expected_windows.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/mssw_pkg.sv
sv/mssw_in_if.sv
sv/mssw_out_if.sv
sv/max_square_window_sum_core.sv
sim/testbench.sv
